// ===== hw/rtl/vna_pkg.sv =====
package vna_pkg;

	typedef enum logic [1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_APPEND = 2'd1,
		KIND_TRI    = 2'd2,
		KIND_READ   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		RES_OK      = 2'd0,
		RES_DEFAULT = 2'd1,
		RES_RANGE   = 2'd2,
		RES_FULL    = 2'd3
	} res_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_CLEAR,
		OP_APPEND,
		OP_RD_VTX,
		OP_EDGE,
		OP_MUL_CROSS,
		OP_RD_SUM,
		OP_LD_SUM,
		OP_MAG,
		OP_SHIFT,
		OP_MUL_SQ,
		OP_SQRT_INIT,
		OP_SQRT_STEP,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_DIV_STORE,
		OP_DEGEN,
		OP_DEFAULT,
		OP_WR_SUM,
		OP_OUT
	} op_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISPATCH,
		S_CLEAR,
		S_APPEND,
		S_TRI_RD,
		S_TRI_WAIT,
		S_EDGE,
		S_CROSS,
		S_CROSS_DRAIN,
		S_RD_SUM,
		S_LD_SUM,
		S_MAG,
		S_SHRINK,
		S_SQ,
		S_SQ_DRAIN,
		S_CHECK,
		S_SQRT_INIT,
		S_SQRT,
		S_DIV_INIT,
		S_DIV,
		S_DIV_STORE,
		S_DEGEN,
		S_DEFAULT,
		S_ACC_RD,
		S_ACC_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		op_t        op;
		logic [2:0] step;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  oor;
		logic  big;
		logic  degen;
		logic  out_busy;
	} sts_t;

	localparam logic [2:0]  SEL_INDEX      = 3'd3;
	localparam logic [61:0] FACE_THRESH_SQ = 62'd184467440737;
	localparam logic [61:0] READ_THRESH_SQ = 62'd2;
	localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
	localparam logic [14:0] Q_MAX          = 15'd16384;
	localparam logic signed [24:0] SUM_MAX = 25'sd8388607;
	localparam logic signed [24:0] SUM_MIN = -25'sd8388608;

endpackage

// ===== hw/rtl/vna_ctrl.sv =====
module vna_ctrl import vna_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t     state_q, state_d;
	logic [4:0] cnt_q, cnt_d;
	logic [1:0] comp_q, comp_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			comp_q  <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			comp_q  <= comp_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		comp_d  = comp_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DISPATCH;
					cnt_d   = '0;
					comp_d  = '0;
				end
			end
			S_DISPATCH: begin
				case (sts.kind)
					KIND_CLEAR:  state_d = S_CLEAR;
					KIND_APPEND: state_d = S_APPEND;
					KIND_TRI:    state_d = sts.oor ? S_DONE : S_TRI_RD;
					KIND_READ:   state_d = sts.oor ? S_DONE : S_RD_SUM;
					default:     state_d = S_DONE;
				endcase
			end
			S_CLEAR, S_APPEND: state_d = S_DONE;
			S_TRI_RD: begin
				if (cnt_q == 5'd2) begin
					cnt_d   = '0;
					state_d = S_TRI_WAIT;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			S_TRI_WAIT: state_d = S_EDGE;
			S_EDGE:     state_d = S_CROSS;
			S_CROSS: begin
				if (cnt_q == 5'd5) begin
					cnt_d   = '0;
					state_d = S_CROSS_DRAIN;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			S_CROSS_DRAIN: state_d = S_MAG;
			S_RD_SUM:      state_d = S_LD_SUM;
			S_LD_SUM:      state_d = S_MAG;
			S_MAG:         state_d = S_SHRINK;
			S_SHRINK: begin
				if (!sts.big) state_d = S_SQ;
			end
			S_SQ: begin
				if (cnt_q == 5'd2) begin
					cnt_d   = '0;
					state_d = S_SQ_DRAIN;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			S_SQ_DRAIN: state_d = S_CHECK;
			S_CHECK: begin
				if (sts.degen) state_d = (sts.kind == KIND_TRI) ? S_DEGEN : S_DEFAULT;
				else state_d = S_SQRT_INIT;
			end
			S_DEGEN:     state_d = S_ACC_RD;
			S_DEFAULT:   state_d = S_DONE;
			S_SQRT_INIT: state_d = S_SQRT;
			S_SQRT: begin
				if (cnt_q == 5'd31) begin
					cnt_d   = '0;
					state_d = S_DIV_INIT;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			S_DIV_INIT: state_d = S_DIV;
			S_DIV: begin
				if (cnt_q == 5'd14) begin
					cnt_d   = '0;
					state_d = S_DIV_STORE;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			S_DIV_STORE: begin
				if (comp_q == 2'd2) begin
					comp_d  = '0;
					state_d = (sts.kind == KIND_TRI) ? S_ACC_RD : S_DONE;
				end else begin
					comp_d  = comp_q + 2'd1;
					state_d = S_DIV_INIT;
				end
			end
			S_ACC_RD: state_d = S_ACC_WR;
			S_ACC_WR: begin
				if (comp_q == 2'd2) begin
					comp_d  = '0;
					state_d = S_DONE;
				end else begin
					comp_d  = comp_q + 2'd1;
					state_d = S_ACC_RD;
				end
			end
			S_DONE: begin
				if (!sts.out_busy) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op   = OP_NONE;
		cmd.step = cnt_q[2:0];
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = OP_ACCEPT;
			end
			S_CLEAR:  cmd.op = OP_CLEAR;
			S_APPEND: cmd.op = OP_APPEND;
			S_TRI_RD: cmd.op = OP_RD_VTX;
			S_EDGE:   cmd.op = OP_EDGE;
			S_CROSS:  cmd.op = OP_MUL_CROSS;
			S_RD_SUM: begin
				cmd.op   = OP_RD_SUM;
				cmd.step = SEL_INDEX;
			end
			S_LD_SUM:    cmd.op = OP_LD_SUM;
			S_MAG:       cmd.op = OP_MAG;
			S_SHRINK:    cmd.op = sts.big ? OP_SHIFT : OP_NONE;
			S_SQ:        cmd.op = OP_MUL_SQ;
			S_SQRT_INIT: cmd.op = OP_SQRT_INIT;
			S_SQRT:      cmd.op = OP_SQRT_STEP;
			S_DIV_INIT: begin
				cmd.op   = OP_DIV_INIT;
				cmd.step = {1'b0, comp_q};
			end
			S_DIV: cmd.op = OP_DIV_STEP;
			S_DIV_STORE: begin
				cmd.op   = OP_DIV_STORE;
				cmd.step = {1'b0, comp_q};
			end
			S_DEGEN:   cmd.op = OP_DEGEN;
			S_DEFAULT: cmd.op = OP_DEFAULT;
			S_ACC_RD: begin
				cmd.op   = OP_RD_SUM;
				cmd.step = {1'b0, comp_q};
			end
			S_ACC_WR: begin
				cmd.op   = OP_WR_SUM;
				cmd.step = {1'b0, comp_q};
			end
			S_DONE: begin
				if (!sts.out_busy) cmd.op = OP_OUT;
			end
			default: cmd.op = OP_NONE;
		endcase
	end

endmodule

// ===== hw/rtl/vna_datapath.sv =====
module vna_datapath import vna_pkg::*; #(
	parameter int MAX_VERTICES = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  cmd_t         cmd,
	output sts_t         sts,
	input  logic [1:0]   in_kind,
	input  logic [135:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [47:0]  out_data,
	output logic [1:0]   out_user
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);

	kind_t       kind_q;
	logic [71:0] coord_q;
	logic [15:0] corner_q [3];
	logic [15:0] vidx_q;
	logic        oor_q;
	res_t        res_st_q;
	logic [CW-1:0] count_q;
	logic        full;

	logic signed [15:0] n_q [3];

	logic [71:0] vtx_mem [MAX_VERTICES];
	logic [71:0] sum_mem [MAX_VERTICES];
	logic [71:0] vtx_rd_q, sum_rd_q;
	logic [15:0] rd_idx;
	logic [AW-1:0] addr;
	logic        sum_we;
	logic [AW-1:0] sum_wa;
	logic [71:0] sum_wd, sat_word;

	logic        cap_v_s1;
	logic [1:0]  cap_slot_s1;
	logic [71:0] pos_q [3];
	logic signed [24:0] e_q [3];
	logic signed [24:0] f_q [3];

	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod_q;
	logic        acc_v_s1, acc_sq_s1;
	logic [2:0]  acc_step_s1;
	logic signed [50:0] vec_q [3];
	logic [50:0] m_q [3];
	logic        sgn_q [3];
	logic [50:0] m_or;
	logic [61:0] lsq_q;

	logic [61:0] sq_v_q;
	logic [62:0] res_q, bit_q;
	logic [63:0] sq_sum;

	logic [31:0] rem_q;
	logic [14:0] lo_q, q_q;
	logic [31:0] den, m_sel;
	logic [32:0] div_t;
	logic        sgn_sel;

	logic        out_v_q;
	logic [47:0] out_data_q;
	logic [1:0]  out_user_q;

	logic [16:0] count_ext;
	logic        in_oor_tri, in_oor_rd;
	logic        in_oor;
	res_t        in_res;

	assign full      = (count_q == CW'(MAX_VERTICES));
	assign count_ext = 17'(count_q);
	assign in_oor_tri = ({1'b0, in_data[87:72]} >= count_ext) ||
	                    ({1'b0, in_data[103:88]} >= count_ext) ||
	                    ({1'b0, in_data[119:104]} >= count_ext);
	assign in_oor_rd = ({1'b0, in_data[135:120]} >= count_ext);

	always_comb begin
		in_oor = 1'b0;
		in_res = RES_OK;
		case (kind_t'(in_kind))
			KIND_APPEND: if (full) in_res = RES_FULL;
			KIND_TRI: begin
				in_oor = in_oor_tri;
				if (in_oor_tri) in_res = RES_RANGE;
			end
			KIND_READ: begin
				in_oor = in_oor_rd;
				if (in_oor_rd) in_res = RES_RANGE;
			end
			default: ;
		endcase
	end

	always_comb begin
		case (cmd.step[1:0])
			2'd0:    rd_idx = corner_q[0];
			2'd1:    rd_idx = corner_q[1];
			2'd2:    rd_idx = corner_q[2];
			default: rd_idx = vidx_q;
		endcase
		addr = rd_idx[AW-1:0];
	end

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			logic signed [24:0] s;
			s = 25'(signed'(sum_rd_q[24*j +: 24])) + 25'(n_q[j]);
			if (s > SUM_MAX) s = SUM_MAX;
			else if (s < SUM_MIN) s = SUM_MIN;
			sat_word[24*j +: 24] = s[23:0];
		end
	end

	always_comb begin
		sum_we = 1'b0;
		sum_wa = addr;
		sum_wd = sat_word;
		if (cmd.op == OP_APPEND && !full) begin
			sum_we = 1'b1;
			sum_wa = count_q[AW-1:0];
			sum_wd = '0;
		end else if (cmd.op == OP_WR_SUM) begin
			sum_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_APPEND && !full) vtx_mem[count_q[AW-1:0]] <= coord_q;
		if (sum_we) sum_mem[sum_wa] <= sum_wd;
		vtx_rd_q <= vtx_mem[addr];
		sum_rd_q <= sum_mem[addr];
	end

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (cmd.op == OP_MUL_CROSS) begin
			case (cmd.step)
				3'd0: begin mul_a = 32'(e_q[1]); mul_b = 32'(f_q[2]); end
				3'd1: begin mul_a = 32'(e_q[2]); mul_b = 32'(f_q[1]); end
				3'd2: begin mul_a = 32'(e_q[2]); mul_b = 32'(f_q[0]); end
				3'd3: begin mul_a = 32'(e_q[0]); mul_b = 32'(f_q[2]); end
				3'd4: begin mul_a = 32'(e_q[0]); mul_b = 32'(f_q[1]); end
				3'd5: begin mul_a = 32'(e_q[1]); mul_b = 32'(f_q[0]); end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end else begin
			case (cmd.step[1:0])
				2'd0:    mul_a = signed'({2'b00, m_q[0][29:0]});
				2'd1:    mul_a = signed'({2'b00, m_q[1][29:0]});
				2'd2:    mul_a = signed'({2'b00, m_q[2][29:0]});
				default: mul_a = '0;
			endcase
			mul_b = mul_a;
		end
	end

	always_comb begin
		case (cmd.step[1:0])
			2'd0:    begin m_sel = m_q[0][31:0]; sgn_sel = sgn_q[0]; end
			2'd1:    begin m_sel = m_q[1][31:0]; sgn_sel = sgn_q[1]; end
			2'd2:    begin m_sel = m_q[2][31:0]; sgn_sel = sgn_q[2]; end
			default: begin m_sel = '0; sgn_sel = 1'b0; end
		endcase
	end

	assign m_or   = m_q[0] | m_q[1] | m_q[2];
	assign sq_sum = {1'b0, res_q} + {1'b0, bit_q};
	assign den    = {res_q[30:0], 1'b0};
	assign div_t  = {rem_q, lo_q[14]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			cap_v_s1 <= 1'b0;
			acc_v_s1 <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.op == OP_CLEAR) count_q <= '0;
			else if (cmd.op == OP_APPEND && !full) count_q <= count_q + CW'(1);
			cap_v_s1 <= (cmd.op == OP_RD_VTX);
			acc_v_s1 <= (cmd.op == OP_MUL_CROSS) || (cmd.op == OP_MUL_SQ);
			if (cmd.op == OP_OUT) out_v_q <= 1'b1;
			else if (out_ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_ACCEPT) begin
			kind_q      <= kind_t'(in_kind);
			coord_q     <= in_data[71:0];
			corner_q[0] <= in_data[87:72];
			corner_q[1] <= in_data[103:88];
			corner_q[2] <= in_data[119:104];
			vidx_q      <= in_data[135:120];
			for (int j = 0; j < 3; j++) n_q[j] <= '0;
			oor_q    <= in_oor;
			res_st_q <= in_res;
		end

		cap_slot_s1 <= cmd.step[1:0];
		if (cap_v_s1) pos_q[cap_slot_s1] <= vtx_rd_q;

		if (cmd.op == OP_EDGE) begin
			for (int j = 0; j < 3; j++) begin
				e_q[j] <= 25'(signed'(pos_q[1][24*j +: 24])) -
				          25'(signed'(pos_q[0][24*j +: 24]));
				f_q[j] <= 25'(signed'(pos_q[2][24*j +: 24])) -
				          25'(signed'(pos_q[0][24*j +: 24]));
			end
		end

		prod_q      <= mul_a * mul_b;
		acc_sq_s1   <= (cmd.op == OP_MUL_SQ);
		acc_step_s1 <= cmd.step;

		if (acc_v_s1 && !acc_sq_s1) begin
			if (!acc_step_s1[0]) vec_q[acc_step_s1[2:1]] <= prod_q[50:0];
			else vec_q[acc_step_s1[2:1]] <= vec_q[acc_step_s1[2:1]] - prod_q[50:0];
		end
		if (cmd.op == OP_LD_SUM) begin
			for (int j = 0; j < 3; j++) vec_q[j] <= 51'(signed'(sum_rd_q[24*j +: 24]));
		end

		if (acc_v_s1 && acc_sq_s1) begin
			if (acc_step_s1 == 3'd0) lsq_q <= prod_q[61:0];
			else lsq_q <= lsq_q + prod_q[61:0];
		end

		if (cmd.op == OP_MAG) begin
			for (int j = 0; j < 3; j++) begin
				sgn_q[j] <= vec_q[j][50];
				m_q[j]   <= vec_q[j][50] ? 51'(-vec_q[j]) : 51'(vec_q[j]);
			end
		end else if (cmd.op == OP_SHIFT) begin
			for (int j = 0; j < 3; j++) m_q[j] <= m_q[j] >> 1;
		end

		if (cmd.op == OP_SQRT_INIT) begin
			sq_v_q <= lsq_q;
			res_q  <= '0;
			bit_q  <= 63'(1) << 62;
		end else if (cmd.op == OP_SQRT_STEP) begin
			if ({2'b00, sq_v_q} >= sq_sum) begin
				sq_v_q <= sq_v_q - sq_sum[61:0];
				res_q  <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end

		if (cmd.op == OP_DIV_INIT) begin
			rem_q <= m_sel + 32'(res_q[31:15]);
			lo_q  <= res_q[14:0];
			q_q   <= '0;
		end else if (cmd.op == OP_DIV_STEP) begin
			if (div_t >= {1'b0, den}) begin
				rem_q <= 32'(div_t - {1'b0, den});
				q_q   <= {q_q[13:0], 1'b1};
			end else begin
				rem_q <= div_t[31:0];
				q_q   <= {q_q[13:0], 1'b0};
			end
			lo_q <= {lo_q[13:0], 1'b0};
		end

		case (cmd.op)
			OP_DIV_STORE: begin
				n_q[cmd.step[1:0]] <= sgn_sel ? -signed'({1'b0, q_q}) : signed'({1'b0, q_q});
			end
			OP_DEGEN: begin
				for (int j = 0; j < 3; j++) begin
					logic [19:0] r;
					r = (20'(m_q[j][18:0]) + 20'h20000) >> 18;
					n_q[j] <= sgn_q[j] ? -signed'(16'(r)) : signed'(16'(r));
				end
				res_st_q <= RES_DEFAULT;
			end
			OP_DEFAULT: begin
				n_q[0]   <= '0;
				n_q[1]   <= ONE_Q14;
				n_q[2]   <= '0;
				res_st_q <= RES_DEFAULT;
			end
			default: ;
		endcase

		if (cmd.op == OP_OUT) begin
			out_data_q <= {n_q[2], n_q[1], n_q[0]};
			out_user_q <= res_st_q;
		end
	end

	always_comb begin
		sts.kind     = kind_q;
		sts.oor      = oor_q;
		sts.big      = |m_or[50:30];
		sts.out_busy = out_v_q && !out_ready;
		if (kind_q == KIND_TRI) sts.degen = !(|m_or[50:19]) && (lsq_q <= FACE_THRESH_SQ);
		else sts.degen = (lsq_q <= READ_THRESH_SQ);
	end

	assign out_valid = out_v_q;
	assign out_data  = out_data_q;
	assign out_user  = out_user_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_VERTICES))
		else $error("vertex count beyond capacity");
	a_quot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_DIV_STORE |-> q_q <= Q_MAX)
		else $error("unit scale above one");
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_SQRT_INIT |-> lsq_q != '0)
		else $error("normalizing a zero vector");
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_OUT |-> (!out_v_q || out_ready))
		else $error("result overwritten before taken");

endmodule

// ===== hw/rtl/vertex_normal_accumulator_core.sv =====
// Vertex store with per-vertex normal accumulators. One item is handled at a
// time: s_tready is high only while the controller is idle, and a finished
// result sits in the output register so the next item can be taken while it
// waits. The run time of a read of a vertex normal or of a triangle is set by the
// 32-step square root, three 15-step divisions and, for large triangles, a
// bit-by-bit reduction of the magnitude before squaring. All multiplications
// share one 32x32 multiplier.
module vertex_normal_accumulator_core import vna_pkg::*; #(
	parameter int MAX_VERTICES = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [135:0] s_tdata,  // coord_x, coord_y, coord_z, corner_a, corner_b, corner_c, vertex_index
	input  logic [1:0]   s_tuser,  // kind
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [47:0]  m_tdata,  // normal_x, normal_y, normal_z
	output logic [1:0]   m_tuser   // status
);

	cmd_t cmd;
	sts_t sts;

	vna_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	vna_datapath #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_kind   (s_tuser),
		.in_data   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_user  (m_tuser)
	);

endmodule

// ===== tb/vna_checker.sv =====
module vna_checker import vna_pkg::*; #(
	parameter int MAX_VERTICES = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [135:0] s_tdata,
	input  logic [1:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [47:0]  m_tdata,
	input  logic [1:0]   m_tuser,
	output int           fails,
	output int           pending,
	output int           results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [15:0] nx;
		logic [15:0] ny;
		logic [15:0] nz;
		res_t        st;
	} normal_beat_t;

	logic signed [23:0] pos_x [MAX_VERTICES];
	logic signed [23:0] pos_y [MAX_VERTICES];
	logic signed [23:0] pos_z [MAX_VERTICES];
	int                 acc_x [MAX_VERTICES];
	int                 acc_y [MAX_VERTICES];
	int                 acc_z [MAX_VERTICES];
	int unsigned        num_verts;
	normal_beat_t       normal_q [$];

	assign pending = normal_q.size();

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - r - b;
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] mag(input longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic int signed_of(input longint ref_v, input logic [63:0] m);
		return ref_v < 0 ? -int'(m) : int'(m);
	endfunction

	// round(m * 1.0 / len) in Q2.14, halves away from zero
	function automatic logic [63:0] to_unit(input logic [63:0] m, input logic [63:0] len);
		return (m * 64'd32768 + len) / (64'd2 * len);
	endfunction

	function automatic int sat24(input int s);
		if (s > 8388607) return 8388607;
		if (s < -8388608) return -8388608;
		return s;
	endfunction

	function automatic void add_normal(input int unsigned v, input int n[3]);
		acc_x[v] = sat24(acc_x[v] + n[0]);
		acc_y[v] = sat24(acc_y[v] + n[1]);
		acc_z[v] = sat24(acc_z[v] + n[2]);
	endfunction

	function automatic void predict_normal(input kind_t kind, input logic [135:0] d);
		int           n[3];
		res_t         st;
		int unsigned  a, b, c, v;
		longint       ex, ey, ez, fx, fy, fz;
		longint       cr[3];
		logic [63:0]  m[3];
		logic [63:0]  mx, lsq, len;
		normal_beat_t e;
		n = '{0, 0, 0};
		st = RES_OK;
		a = d[87:72];
		b = d[103:88];
		c = d[119:104];
		v = d[135:120];
		case (kind)
			KIND_CLEAR: num_verts = 0;
			KIND_APPEND: begin
				if (num_verts < MAX_VERTICES) begin
					pos_x[num_verts] = d[23:0];
					pos_y[num_verts] = d[47:24];
					pos_z[num_verts] = d[71:48];
					acc_x[num_verts] = 0;
					acc_y[num_verts] = 0;
					acc_z[num_verts] = 0;
					num_verts++;
				end else begin
					st = RES_FULL;
				end
			end
			KIND_TRI: begin
				if (a >= num_verts || b >= num_verts || c >= num_verts) begin
					st = RES_RANGE;
				end else begin
					ex = longint'(pos_x[b]) - longint'(pos_x[a]);
					ey = longint'(pos_y[b]) - longint'(pos_y[a]);
					ez = longint'(pos_z[b]) - longint'(pos_z[a]);
					fx = longint'(pos_x[c]) - longint'(pos_x[a]);
					fy = longint'(pos_y[c]) - longint'(pos_y[a]);
					fz = longint'(pos_z[c]) - longint'(pos_z[a]);
					cr[0] = ey * fz - ez * fy;
					cr[1] = ez * fx - ex * fz;
					cr[2] = ex * fy - ey * fx;
					mx = 0;
					for (int i = 0; i < 3; i++) begin
						m[i] = mag(cr[i]);
						if (m[i] > mx) mx = m[i];
					end
					lsq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
					if (mx < (64'd1 << 19) && lsq <= 64'(FACE_THRESH_SQ)) begin
						st = RES_DEFAULT;
						for (int i = 0; i < 3; i++)
							n[i] = signed_of(cr[i], (m[i] + (64'd1 << 17)) >> 18);
					end else begin
						while (mx >= (64'd1 << 30)) begin
							mx = mx >> 1;
							for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
						end
						len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
						for (int i = 0; i < 3; i++) n[i] = signed_of(cr[i], to_unit(m[i], len));
					end
					add_normal(a, n);
					add_normal(b, n);
					add_normal(c, n);
				end
			end
			default: begin
				if (v >= num_verts) begin
					st = RES_RANGE;
				end else begin
					cr[0] = acc_x[v];
					cr[1] = acc_y[v];
					cr[2] = acc_z[v];
					for (int i = 0; i < 3; i++) m[i] = mag(cr[i]);
					lsq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
					if (lsq <= 64'(READ_THRESH_SQ)) begin
						n[1] = int'(ONE_Q14);
						st = RES_DEFAULT;
					end else begin
						len = int_sqrt(lsq);
						for (int i = 0; i < 3; i++) n[i] = signed_of(cr[i], to_unit(m[i], len));
					end
				end
			end
		endcase
		e.nx = n[0][15:0];
		e.ny = n[1][15:0];
		e.nz = n[2][15:0];
		e.st = st;
		normal_q.push_back(e);
	endfunction

	initial begin
		fails = 0;
		results_seen = 0;
		num_verts = 0;
	end

	always @(posedge clk) begin
		normal_beat_t e;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (normal_q.size() == 0) begin
					fails++;
					$display("%0t: unexpected result beat n=%h status=%0d", $time,
						m_tdata, m_tuser);
				end else begin
					e = normal_q.pop_front();
					if (m_tdata[15:0] !== e.nx || m_tdata[31:16] !== e.ny ||
						m_tdata[47:32] !== e.nz || m_tuser !== e.st) begin
						fails++;
						$display("%0t: mismatch expected n=(%0d,%0d,%0d) status=%0d, actual n=(%0d,%0d,%0d) status=%0d",
							$time, $signed(e.nx), $signed(e.ny), $signed(e.nz), e.st,
							$signed(m_tdata[15:0]), $signed(m_tdata[31:16]),
							$signed(m_tdata[47:32]), m_tuser);
					end
				end
			end
			if (s_tvalid && s_tready)
				predict_normal(kind_t'(s_tuser), s_tdata);
		end
	end

endmodule

// ===== tb/vertex_normal_accumulator_core_tb.sv =====
module vertex_normal_accumulator_core_tb import vna_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NV = 1024;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [135:0] s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [47:0]  m_tdata;
	logic [1:0]   m_tuser;

	int fails, pending, results_seen;
	int src_idle = 0, snk_idle = 0;
	int unsigned vert_count = 0;
	int beats_sent = 0;
	int stall_cycles = 0;

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	vertex_normal_accumulator_core #(.MAX_VERTICES(NV)) DUT (.*);

	vna_checker #(.MAX_VERTICES(NV)) u_checker (.*);

	always @(posedge clk) begin
		if (arst_n)
			m_tready <= ($urandom_range(99) >= snk_idle);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles > 5000) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_beat(input kind_t kind, input logic [135:0] d);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= kind;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		beats_sent++;
	endtask

	function automatic logic [135:0] noise();
		logic [135:0] d;
		for (int i = 0; i < 5; i++) d[i*32 +: 32] = $urandom;
		return d;
	endfunction

	task automatic do_clear();
		send_beat(KIND_CLEAR, noise());
		vert_count = 0;
	endtask

	task automatic do_append(input logic [23:0] x, input logic [23:0] y, input logic [23:0] z);
		logic [135:0] d;
		d = noise();
		d[71:0] = {z, y, x};
		send_beat(KIND_APPEND, d);
		if (vert_count < NV) vert_count++;
	endtask

	task automatic do_tri(input logic [15:0] a, input logic [15:0] b, input logic [15:0] c);
		logic [135:0] d;
		d = noise();
		d[119:72] = {c, b, a};
		send_beat(KIND_TRI, d);
	endtask

	task automatic do_read(input logic [15:0] v);
		logic [135:0] d;
		d = noise();
		d[135:120] = v;
		send_beat(KIND_READ, d);
	endtask

	function automatic logic [23:0] rand_coord(input int scale);
		case (scale)
			0: return 24'($urandom);
			1: return 24'($signed($urandom_range(32767)) - 16384);
			default: return 24'($signed($urandom_range(7)) - 3);
		endcase
	endfunction

	function automatic logic [15:0] pick_index();
		if (vert_count == 0 || $urandom_range(99) < 15) return 16'($urandom_range(65535));
		return 16'($urandom_range(vert_count - 1));
	endfunction

	task automatic random_items(input int n);
		int scale;
		int r;
		scale = 0;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(19) == 0) scale = $urandom_range(2);
			r = $urandom_range(99);
			if (vert_count < 3 || (r >= 3 && r < 28))
				do_append(rand_coord(scale), rand_coord(scale), rand_coord(scale));
			else if (r < 3)
				do_clear();
			else if (r < 73)
				do_tri(pick_index(), pick_index(), pick_index());
			else
				do_read(pick_index());
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty store, extremes, degenerate and out-of-range cases
		do_read(0);
		do_tri(0, 1, 2);
		do_append(24'h7fffff, 24'h7fffff, 24'h7fffff);
		do_append(24'h800000, 24'h800000, 24'h800000);
		do_append(24'h800000, 24'h7fffff, 24'h000000);
		do_tri(0, 1, 2);
		do_tri(0, 2, 1);
		do_tri(1, 1, 1);
		do_read(0);
		do_read(2);
		do_tri(0, 1, 16'hffff);
		do_read(16'hffff);
		do_read(3);
		do_append(0, 0, 0);
		do_append(24'd1, 0, 0);
		do_append(0, 24'd1, 0);
		do_tri(3, 4, 5);
		do_read(5);
		do_append(24'd120, 0, 0);
		do_append(0, 24'd120, 0);
		do_tri(3, 6, 7);
		do_read(3);
		do_clear();
		do_read(0);
		wait_drained();

		src_idle = 9;
		snk_idle = 70;
		random_items(145);
		wait_drained();
		src_idle = 70;
		snk_idle = 9;
		random_items(145);
		src_idle = 0;
		snk_idle = 0;
		random_items(145);

		// face normal (-x,+y) drives x to the low limit and y to the high one
		do_clear();
		do_append(0, 0, 0);
		do_append(0, 0, 24'h010000);
		do_append(24'h010000, 24'h010000, 0);
		for (int i = 0; i < 740; i++) do_tri(0, 1, 2);
		do_read(0);
		for (int i = 0; i < 5; i++) do_tri(0, 2, 1);
		do_read(0);
		do_read(1);

		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Sent %0d beats, checked %0d results: directed cases and three idle profiles,",
			beats_sent, results_seen);
		$display("plus accumulator saturation at both limits on one vertex.");
		if (fails == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/vna_pkg.sv
hw/rtl/vna_ctrl.sv
hw/rtl/vna_datapath.sv
hw/rtl/vertex_normal_accumulator_core.sv
tb/vna_checker.sv
tb/vertex_normal_accumulator_core_tb.sv
